>>> hdl/afc_pkg.sv
`default_nettype none

package afc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FRAMING  = 2'd1,
        STATUS_ID_CMD   = 2'd2,
        STATUS_CHECKSUM = 2'd3
    } afc_status_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_PREFIX     = 3'd0;
    localparam logic [2:0] CFG_POSTFIX    = 3'd1;
    localparam logic [2:0] CFG_EXP_ID     = 3'd2;
    localparam logic [2:0] CFG_REQ_CMD    = 3'd3;
    localparam logic [2:0] CFG_PRINTER    = 3'd4;
    localparam logic [2:0] CFG_MIN_LENGTH = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Hard floor on frame length, whatever min_length says
    localparam logic [7:0] MIN_FRAME_FLOOR = 8'd8;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LVL_W = 3;

    // Configuration as seen by the frame checker
    typedef struct packed {
        logic [7:0]  prefix_byte;
        logic [7:0]  postfix_byte;
        logic [7:0]  expected_id;
        logic [15:0] request_command;
        logic        printer_mode;
        logic [7:0]  min_length;
    } afc_cfg_t;

    // One result transfer
    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        afc_status_t status;
        logic        run_last;
    } afc_result_t;

    // Decoded ASCII hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } afc_hex_t;

    function automatic afc_hex_t hex_decode(input logic [7:0] c);
        afc_hex_t h;
        logic [7:0] t;
        h = '0;
        t = '0;
        if (c >= 8'h30 && c <= 8'h39) begin          // '0'..'9'
            h.ok    = 1'b1;
            h.value = c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin // 'A'..'F'
            t       = c - 8'h37;
            h.ok    = 1'b1;
            h.value = t[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin // 'a'..'f'
            t       = c - 8'h57;
            h.ok    = 1'b1;
            h.value = t[3:0];
        end
        return h;
    endfunction

endpackage

`default_nettype wire

>>> hdl/afc_frame_check.sv
`default_nettype none

module afc_frame_check #(
    parameter int MAX_FRAME = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fire,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    input  wire afc_pkg::afc_cfg_t   cfg,
    output logic [1:0]               wr_cnt,
    output afc_pkg::afc_result_t     wr_data0,
    output afc_pkg::afc_result_t     wr_data1
);
    import afc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = (CW + 1 > 8) ? CW + 1 : 8;

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    tail_reg [6];
    logic [7:0]    tail_next [6];
    logic [15:0]   sum_reg, sum_next;
    logic [2:0]    flags_reg, flags_next;

    logic [LW-1:0] len;
    logic [7:0]    need;
    logic          emit_payload;
    afc_hex_t      d0, d1, d2, d3;
    logic [15:0]   crc;
    afc_status_t   st;
    afc_result_t   pay_res, st_res;

    // Header echo checks
    always_comb begin
        flags_next = flags_reg;
        if (count_reg == CW'(0) && in_byte != cfg.prefix_byte)
            flags_next[0] = 1'b1;
        if (count_reg == CW'(1) && in_byte != cfg.expected_id)
            flags_next[1] = 1'b1;
        if (count_reg == CW'(2) && in_byte != cfg.request_command[15:8])
            flags_next[2] = 1'b1;
        if (count_reg == CW'(3) && in_byte != cfg.request_command[7:0])
            flags_next[2] = 1'b1;
    end

    // Sum trails the input by four bytes
    assign sum_next = (count_reg >= CW'(4)) ? sum_reg + 16'(tail_reg[3]) : sum_reg;

    // Trailer: four hex digits, byte pairs swapped
    assign d0  = hex_decode(tail_reg[2]);
    assign d1  = hex_decode(tail_reg[1]);
    assign d2  = hex_decode(tail_reg[0]);
    assign d3  = hex_decode(in_byte);
    assign crc = {d2.value, d3.value, d0.value, d1.value};

    assign len  = LW'(count_reg) + LW'(1);
    assign need = (cfg.min_length < MIN_FRAME_FLOOR) ? MIN_FRAME_FLOOR : cfg.min_length;

    // Status priority: framing, echo, checksum
    always_comb begin
        if (len < LW'(need) || flags_next[0] || tail_reg[3] != cfg.postfix_byte) begin
            st = STATUS_FRAMING;
        end else if (!cfg.printer_mode && flags_next[2:1] != 2'b00) begin
            st = STATUS_ID_CMD;
        end else if (!(d0.ok && d1.ok && d2.ok && d3.ok) || crc != sum_next) begin
            st = STATUS_CHECKSUM;
        end else begin
            st = STATUS_OK;
        end
    end

    // Result assembly
    assign emit_payload = (count_reg >= CW'(8));

    always_comb begin
        pay_res              = '0;
        pay_res.is_status    = 1'b0;
        pay_res.payload_byte = tail_reg[5];
        pay_res.status       = STATUS_OK;
        pay_res.run_last     = !in_last;

        st_res               = '0;
        st_res.is_status     = 1'b1;
        st_res.payload_byte  = 8'd0;
        st_res.status        = st;
        st_res.run_last      = 1'b1;

        wr_cnt   = 2'd0;
        wr_data0 = pay_res;
        wr_data1 = st_res;
        if (fire) begin
            if (emit_payload && in_last) begin
                wr_cnt = 2'd2;
            end else if (emit_payload) begin
                wr_cnt = 2'd1;
            end else if (in_last) begin
                wr_cnt   = 2'd1;
                wr_data0 = st_res;
            end
        end
    end

    // Frame state update; cleared after every frame end
    always_comb begin
        count_next = count_reg;
        if (count_reg < CW'(MAX_FRAME))
            count_next = count_reg + CW'(1);
        tail_next[0] = in_byte;
        for (int k = 1; k < 6; k++)
            tail_next[k] = tail_reg[k-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            flags_reg <= '0;
            for (int k = 0; k < 6; k++)
                tail_reg[k] <= '0;
        end else if (fire) begin
            if (in_last) begin
                count_reg <= '0;
                sum_reg   <= '0;
                flags_reg <= '0;
                for (int k = 0; k < 6; k++)
                    tail_reg[k] <= '0;
            end else begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                flags_reg <= flags_next;
                for (int k = 0; k < 6; k++)
                    tail_reg[k] <= tail_next[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/afc_result_fifo.sv
`default_nettype none

module afc_result_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [1:0]            wr_cnt,
    input  wire afc_pkg::afc_result_t  wr_data0,
    input  wire afc_pkg::afc_result_t  wr_data1,
    output logic                       rd_valid,
    input  wire logic                  rd_ready,
    output afc_pkg::afc_result_t       rd_data,
    output logic [afc_pkg::Q_LVL_W-1:0] level
);
    import afc_pkg::*;

    afc_result_t          mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_LVL_W-1:0]   level_reg, level_next;
    logic                 pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (level_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign level    = level_reg;

    assign level_next = level_reg + Q_LVL_W'(wr_cnt) - Q_LVL_W'(pop);

    // Storage: up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0)
            mem[wr_ptr_reg] <= wr_data0;
        if (wr_cnt == 2'd2)
            mem[wr_ptr_reg + Q_PTR_W'(1)] <= wr_data1;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(wr_cnt);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/answer_frame_checker_core.sv
`default_nettype none

// Answer frame checker. Takes one frame byte per transfer on the s_ side
// (s_frame_end on the last byte) and sustains one byte per clock cycle.
// Bytes 2 to n-7 leave on the m_ side as payload transfers, six bytes behind
// the input, before the frame is verified; the frame-end byte adds one status
// transfer (ok, framing, id/command, checksum) that the user should consult
// before trusting the payload. A byte passes an input register, then the
// checker logic, then a four-entry result queue. Since the frame-end byte
// can give two results on a one-result-per-cycle output, input stalls
// whenever the queue holds three or more results. Configuration writes are
// taken at any time but must only be issued while no frame is in progress.
module answer_frame_checker_core #(
    parameter int MAX_FRAME = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input bytes
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_answer_byte,
    input  wire logic                          s_frame_end,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_is_status,
    output logic [7:0]                         m_payload_byte,
    output logic [1:0]                         m_status,
    output logic                               m_run_last
);
    import afc_pkg::*;

    afc_cfg_t            cfg_reg;
    logic                in_vld_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                fire;
    logic [1:0]          wr_cnt;
    afc_result_t         wr_data0, wr_data1, rd_data;
    logic [Q_LVL_W-1:0]  q_level;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prefix_byte     <= 8'd2;
            cfg_reg.postfix_byte    <= 8'd3;
            cfg_reg.expected_id     <= 8'd32;
            cfg_reg.request_command <= 16'd0;
            cfg_reg.printer_mode    <= 1'b0;
            cfg_reg.min_length      <= 8'd8;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_PREFIX:     cfg_reg.prefix_byte     <= cfg_data[7:0];
                CFG_POSTFIX:    cfg_reg.postfix_byte    <= cfg_data[7:0];
                CFG_EXP_ID:     cfg_reg.expected_id     <= cfg_data[7:0];
                CFG_REQ_CMD:    cfg_reg.request_command <= cfg_data;
                CFG_PRINTER:    cfg_reg.printer_mode    <= cfg_data[0];
                CFG_MIN_LENGTH: cfg_reg.min_length      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register; advances when the queue can absorb two results
    assign fire    = in_vld_reg && (q_level <= Q_LVL_W'(Q_DEPTH - 2));
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_answer_byte;
            in_last_reg <= s_frame_end;
        end
    end

    afc_frame_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .cfg      (cfg_reg),
        .wr_cnt   (wr_cnt),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1)
    );

    afc_result_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cnt   (wr_cnt),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (rd_data),
        .level    (q_level)
    );

    assign m_is_status    = rd_data.is_status;
    assign m_payload_byte = rd_data.payload_byte;
    assign m_status       = rd_data.status;
    assign m_run_last     = rd_data.run_last;

`ifndef SYNTHESIS
    // Queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= Q_LVL_W'(Q_DEPTH))
        else $error("result queue overflow");

    // A status transfer always closes its run
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_run_last)
        else $error("status result without run_last");

    // Payload transfers carry a zero status field
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |-> m_status == STATUS_OK)
        else $error("payload result with non-zero status");

    // An item in the input register leaves once the queue has room
    a_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && q_level == '0 |=> !in_vld_reg || $past(s_valid && s_ready))
        else $error("input register stuck with empty queue");
`endif

endmodule

`default_nettype wire
